### sv/vau_pkg.sv
// Shared types, constants and saturation helpers for the vector arithmetic unit.
package vau_pkg;

   localparam int DATA_W        = 32;
   localparam int KIND_W        = 4;
   localparam int PROD_W        = 64;
   localparam int WIDE_W        = 66;
   localparam int FRAC_BITS_DEF = 16;

   typedef logic [KIND_W-1:0] kind_type;

   localparam kind_type KIND_ADD    = 4'd0;
   localparam kind_type KIND_SUB    = 4'd1;
   localparam kind_type KIND_SCALE  = 4'd2;
   localparam kind_type KIND_DIVIDE = 4'd3;
   localparam kind_type KIND_NEGATE = 4'd4;
   localparam kind_type KIND_DOT    = 4'd5;
   localparam kind_type KIND_CROSS  = 4'd6;
   localparam kind_type KIND_MAG    = 4'd7;
   localparam kind_type KIND_PASS   = 4'd8;

   localparam logic [DATA_W-1:0] MAX_VAL = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] MIN_VAL = 32'h8000_0000;

   typedef struct packed {
      logic              ovf;
      logic [DATA_W-1:0] val;
   } res_type;

   // Clamp a wide signed value to 32 bits; in range exactly when the top bits agree.
   function automatic res_type sat_wide(input logic signed [WIDE_W-1:0] v);
      res_type r;
      if ((&v[WIDE_W-1:DATA_W-1]) || (~|v[WIDE_W-1:DATA_W-1])) begin
         r.ovf = 1'b0;
         r.val = v[DATA_W-1:0];
      end else begin
         r.ovf = 1'b1;
         r.val = v[WIDE_W-1] ? MIN_VAL : MAX_VAL;
      end
      return r;
   endfunction

   // Round to nearest with ties toward plus infinity, then clamp.
   function automatic res_type round_sat(input logic signed [WIDE_W-1:0] s,
                                         input int unsigned frac);
      logic signed [WIDE_W-1:0] t;
      t = (s + (66'sd1 <<< (frac - 1))) >>> frac;
      return sat_wide(t);
   endfunction

endpackage

### sv/vau_req_if.sv
// Request channel: operation kind, two vectors and a scalar.
interface vau_req_if;
   logic                   valid;
   logic                   ready;
   vau_pkg::kind_type      kind;
   logic signed [31:0]     ax;
   logic signed [31:0]     ay;
   logic signed [31:0]     az;
   logic signed [31:0]     bx;
   logic signed [31:0]     by;
   logic signed [31:0]     bz;
   logic signed [31:0]     scale_value;

   modport source (output valid, kind, ax, ay, az, bx, by, bz, scale_value, input ready);
   modport sink   (input valid, kind, ax, ay, az, bx, by, bz, scale_value, output ready);
endinterface

### sv/vau_rsp_if.sv
// Response channel: vector result, scalar result and status flags.
interface vau_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_z;
   logic signed [31:0] out_scalar;
   logic               overflow;
   logic               divide_by_zero;

   modport source (output valid, out_x, out_y, out_z, out_scalar, overflow, divide_by_zero,
                   input ready);
   modport sink   (input valid, out_x, out_y, out_z, out_scalar, overflow, divide_by_zero,
                   output ready);
endinterface

### sv/vau_div.sv
// Pipelined restoring divider: (a << FRAC_BITS) / d, truncated, saturated.
module vau_div #(
   parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               advance,
   input  logic signed [31:0] dividend,
   input  logic signed [31:0] divisor,
   output vau_pkg::res_type   result
);

   localparam int DW = vau_pkg::DATA_W + FRAC_BITS;
   localparam logic [DW-1:0] LIM_POS = DW'(32'h7FFF_FFFF);
   localparam logic [DW-1:0] LIM_NEG = DW'(32'h8000_0000);

   typedef struct packed {
      logic [31:0] den;
      logic        neg;
      logic        zero_den;
      logic        a_neg;
      logic        a_zero;
   } side_type;

   logic [31:0]      a_mag;
   logic [31:0]      d_mag;
   logic [DW-1:0]    dq_prep_ff;
   side_type         side_prep_ff;
   logic [DW-1:0]    dq_ff   [DW];
   logic [31:0]      rem_ff  [DW];
   side_type         side_ff [DW];
   vau_pkg::res_type res_in;
   vau_pkg::res_type res_ff;
   logic [DW-1:0]    q;
   side_type         s_last;

   assign a_mag = dividend[31] ? (32'd0 - unsigned'(dividend)) : unsigned'(dividend);
   assign d_mag = divisor[31]  ? (32'd0 - unsigned'(divisor))  : unsigned'(divisor);

   always_ff @(posedge clock) begin
      if (advance) begin
         dq_prep_ff            <= {a_mag, {FRAC_BITS{1'b0}}};
         side_prep_ff.den      <= d_mag;
         side_prep_ff.neg      <= dividend[31] ^ divisor[31];
         side_prep_ff.zero_den <= (divisor == 32'sd0);
         side_prep_ff.a_neg    <= dividend[31];
         side_prep_ff.a_zero   <= (dividend == 32'sd0);
      end
   end

   // One quotient bit per stage, most significant first.
   for (genvar k = 0; k < DW; k++) begin : g_step
      logic [DW-1:0] prev_dq;
      logic [31:0]   prev_rem;
      side_type      prev_side;
      logic [32:0]   trial;
      logic [32:0]   diff;
      logic          ge;

      if (k == 0) begin : g_first
         assign prev_dq   = dq_prep_ff;
         assign prev_rem  = 32'd0;
         assign prev_side = side_prep_ff;
      end else begin : g_next
         assign prev_dq   = dq_ff[k-1];
         assign prev_rem  = rem_ff[k-1];
         assign prev_side = side_ff[k-1];
      end

      assign trial = {prev_rem, prev_dq[DW-1]};
      assign diff  = trial - {1'b0, prev_side.den};
      assign ge    = (trial >= {1'b0, prev_side.den});

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= ge ? diff[31:0] : trial[31:0];
            dq_ff[k]   <= {prev_dq[DW-2:0], ge};
            side_ff[k] <= prev_side;
         end
      end
   end

   assign q      = dq_ff[DW-1];
   assign s_last = side_ff[DW-1];

   always_comb begin
      res_in.ovf = 1'b0;
      res_in.val = q[31:0];
      if (s_last.zero_den) begin
         // Division by zero saturates by the dividend's sign without overflow; a zero dividend gives zero.
         res_in.val = s_last.a_neg ? vau_pkg::MIN_VAL :
                      (s_last.a_zero ? 32'd0 : vau_pkg::MAX_VAL);
      end else if (s_last.neg) begin
         if (q > LIM_NEG) begin
            res_in.ovf = 1'b1;
            res_in.val = vau_pkg::MIN_VAL;
         end else begin
            res_in.val = 32'd0 - q[31:0];
         end
      end else if (q > LIM_POS) begin
         res_in.ovf = 1'b1;
         res_in.val = vau_pkg::MAX_VAL;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

### sv/vau_sqrt.sv
// Pipelined integer square root of a 64-bit value, two radicand bits per stage.
module vau_sqrt (
   input  logic        clock,
   input  logic        advance,
   input  logic [63:0] radicand,
   output logic [31:0] root
);

   localparam int STEPS = 32;

   logic [32:0] rem_ff  [STEPS];
   logic [31:0] root_ff [STEPS];
   logic [63:0] n_ff    [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [32:0] prev_rem;
      logic [31:0] prev_root;
      logic [63:0] prev_n;
      logic [34:0] rem_sh;
      logic [34:0] trial;
      logic [34:0] diff;
      logic        ge;

      if (k == 0) begin : g_first
         assign prev_rem  = 33'd0;
         assign prev_root = 32'd0;
         assign prev_n    = radicand;
      end else begin : g_next
         assign prev_rem  = rem_ff[k-1];
         assign prev_root = root_ff[k-1];
         assign prev_n    = n_ff[k-1];
      end

      assign rem_sh = {prev_rem, prev_n[63:62]};
      assign trial  = {1'b0, prev_root, 2'b01};
      assign diff   = rem_sh - trial;
      assign ge     = (rem_sh >= trial);

      // The remainder never exceeds twice the partial root, so 33 bits hold it.
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= ge ? diff[32:0] : rem_sh[32:0];
            root_ff[k] <= {prev_root[30:0], ge};
            n_ff[k]    <= {prev_n[61:0], 2'b00};
         end
      end
   end

   assign root = root_ff[STEPS-1];

endmodule

### sv/vau_lane.sv
// One component lane: add/sub/negate/pass, scale and cross products, divide, and a product term for dot and magnitude.
module vau_lane #(
   parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               advance,
   input  vau_pkg::kind_type  kind,
   input  logic signed [31:0] a_i,
   input  logic signed [31:0] a_j,
   input  logic signed [31:0] a_k,
   input  logic signed [31:0] b_i,
   input  logic signed [31:0] b_j,
   input  logic signed [31:0] b_k,
   input  logic signed [31:0] scale_value,
   output logic signed [63:0] prod,
   output vau_pkg::res_type   result
);

   // Results line up with the divider output, which sits DLY stages after stage two.
   localparam int DLY = vau_pkg::DATA_W + FRAC_BITS;

   logic signed [vau_pkg::WIDE_W-1:0] fast_sum;
   vau_pkg::res_type                  fast_in;
   logic signed [31:0]                m0a;
   logic signed [31:0]                m0b;
   vau_pkg::kind_type                 kind1_ff;
   vau_pkg::res_type                  fast1_ff;
   logic signed [63:0]                p0_ff;
   logic signed [63:0]                p1_ff;
   logic signed [vau_pkg::WIDE_W-1:0] sum2;
   vau_pkg::res_type                  rnd2;
   vau_pkg::res_type                  res2_in;
   vau_pkg::res_type                  res2_ff;
   logic                              is_div2_ff;
   vau_pkg::res_type                  res_line_ff [DLY];
   logic                              div_line_ff [DLY];
   vau_pkg::res_type                  div_res;

   always_comb begin
      case (kind)
         vau_pkg::KIND_ADD:    fast_sum = 66'(a_i) + 66'(b_i);
         vau_pkg::KIND_SUB:    fast_sum = 66'(a_i) - 66'(b_i);
         vau_pkg::KIND_NEGATE: fast_sum = 66'sd0 - 66'(a_i);
         vau_pkg::KIND_PASS:   fast_sum = 66'(a_i);
         default:              fast_sum = 66'sd0;
      endcase
      fast_in = vau_pkg::sat_wide(fast_sum);
   end

   // The first multiplier covers scale, dot, magnitude and one cross term.
   always_comb begin
      m0a = (kind == vau_pkg::KIND_CROSS) ? a_j : a_i;
      case (kind)
         vau_pkg::KIND_SCALE: m0b = scale_value;
         vau_pkg::KIND_DOT:   m0b = b_i;
         vau_pkg::KIND_MAG:   m0b = a_i;
         default:             m0b = b_k;
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kind1_ff <= kind;
         fast1_ff <= fast_in;
         p0_ff    <= m0a * m0b;
         p1_ff    <= a_k * b_j;
      end
   end

   always_comb begin
      if (kind1_ff == vau_pkg::KIND_CROSS) begin
         sum2 = 66'(p0_ff) - 66'(p1_ff);
      end else begin
         sum2 = 66'(p0_ff);
      end
      rnd2 = vau_pkg::round_sat(sum2, FRAC_BITS);
      if (kind1_ff == vau_pkg::KIND_SCALE || kind1_ff == vau_pkg::KIND_CROSS) begin
         res2_in = rnd2;
      end else begin
         res2_in = fast1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res2_ff        <= res2_in;
         is_div2_ff     <= (kind1_ff == vau_pkg::KIND_DIVIDE);
         res_line_ff[0] <= res2_ff;
         div_line_ff[0] <= is_div2_ff;
         for (int i = 1; i < DLY; i++) begin
            res_line_ff[i] <= res_line_ff[i-1];
            div_line_ff[i] <= div_line_ff[i-1];
         end
      end
   end

   vau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock    (clock),
      .advance  (advance),
      .dividend (a_i),
      .divisor  (scale_value),
      .result   (div_res)
   );

   assign prod   = p0_ff;
   assign result = div_line_ff[DLY-1] ? div_res : res_line_ff[DLY-1];

endmodule

### sv/vau_merge.sv
// Merging stage: dot product and magnitude from the lane products, plus flags.
module vau_merge #(
   parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               advance,
   input  vau_pkg::kind_type  kind,
   input  logic signed [31:0] scale_value,
   input  logic signed [63:0] prod_x,
   input  logic signed [63:0] prod_y,
   input  logic signed [63:0] prod_z,
   output vau_pkg::res_type   result,
   output logic               divide_by_zero
);

   localparam int DLY      = vau_pkg::DATA_W + FRAC_BITS;
   localparam int ROOT_DLY = DLY - 32;

   typedef struct packed {
      vau_pkg::kind_type kind;
      logic              dz;
   } ctrl_type;

   ctrl_type         ctrl1_ff;
   ctrl_type         ctrl2_ff;
   vau_pkg::res_type dot2_ff;
   logic [63:0]      sq2_ff;
   logic [31:0]      root;
   ctrl_type         ctrl_line_ff [DLY];
   vau_pkg::res_type dot_line_ff  [DLY];
   logic [31:0]      root_line_ff [ROOT_DLY];
   ctrl_type         ctrl_d;
   logic [31:0]      root_d;

   always_ff @(posedge clock) begin
      if (advance) begin
         ctrl1_ff.kind <= kind;
         ctrl1_ff.dz   <= (kind == vau_pkg::KIND_DIVIDE) && (scale_value == 32'sd0);
         ctrl2_ff      <= ctrl1_ff;
         dot2_ff       <= vau_pkg::round_sat(66'(prod_x) + 66'(prod_y) + 66'(prod_z),
                                             FRAC_BITS);
         // Squares are non-negative and at most 2^62 each, so the sum fits 64 bits.
         sq2_ff        <= unsigned'(prod_x) + unsigned'(prod_y) + unsigned'(prod_z);
         ctrl_line_ff[0] <= ctrl2_ff;
         dot_line_ff[0]  <= dot2_ff;
         for (int i = 1; i < DLY; i++) begin
            ctrl_line_ff[i] <= ctrl_line_ff[i-1];
            dot_line_ff[i]  <= dot_line_ff[i-1];
         end
         root_line_ff[0] <= root;
         for (int i = 1; i < ROOT_DLY; i++) begin
            root_line_ff[i] <= root_line_ff[i-1];
         end
      end
   end

   vau_sqrt u_sqrt (
      .clock    (clock),
      .advance  (advance),
      .radicand (sq2_ff),
      .root     (root)
   );

   assign ctrl_d = ctrl_line_ff[DLY-1];
   assign root_d = root_line_ff[ROOT_DLY-1];

   always_comb begin
      result.ovf = 1'b0;
      result.val = 32'd0;
      case (ctrl_d.kind)
         vau_pkg::KIND_DOT: begin
            result = dot_line_ff[DLY-1];
         end
         vau_pkg::KIND_MAG: begin
            result.ovf = root_d[31];
            result.val = root_d[31] ? vau_pkg::MAX_VAL : root_d;
         end
         default: begin
            result.ovf = 1'b0;
            result.val = 32'd0;
         end
      endcase
   end

   assign divide_by_zero = ctrl_d.dz;

endmodule

### sv/vector3_arithmetic_unit.sv
// Three-component vector ALU in signed fixed point with FRAC_BITS fraction bits.
// The unit accepts one item every clock while the output is not stalled and returns
// one result per item, in order. The divider sets the pipeline depth; it resolves one
// quotient bit per pipeline stage over 32 + FRAC_BITS stages. The whole pipeline
// holds while a result waits at the output, so req_if.ready follows rsp_if.ready
// whenever the output register is full.
module vector3_arithmetic_unit #(
   parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEF
) (
   input  logic   clock,
   input  logic   reset,
   vau_req_if.sink   req_if,
   vau_rsp_if.source rsp_if
);

   // Stages from acceptance to the last lane and merge register.
   localparam int DEPTH = vau_pkg::DATA_W + FRAC_BITS + 2;

   logic               advance;
   logic [DEPTH-1:0]   valid_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] a_vec [3];
   logic signed [31:0] b_vec [3];
   logic signed [63:0] lane_prod [3];
   vau_pkg::res_type   lane_res  [3];
   vau_pkg::res_type   merge_res;
   logic               merge_dz;
   logic [31:0]        out_x_ff;
   logic [31:0]        out_y_ff;
   logic [31:0]        out_z_ff;
   logic [31:0]        out_scalar_ff;
   logic               overflow_ff;
   logic               dz_ff;

   assign advance = !rsp_valid_ff || rsp_if.ready;

   assign a_vec[0] = req_if.ax;
   assign a_vec[1] = req_if.ay;
   assign a_vec[2] = req_if.az;
   assign b_vec[0] = req_if.bx;
   assign b_vec[1] = req_if.by;
   assign b_vec[2] = req_if.bz;

   for (genvar i = 0; i < 3; i++) begin : g_lane
      vau_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock       (clock),
         .advance     (advance),
         .kind        (req_if.kind),
         .a_i         (a_vec[i]),
         .a_j         (a_vec[(i + 1) % 3]),
         .a_k         (a_vec[(i + 2) % 3]),
         .b_i         (b_vec[i]),
         .b_j         (b_vec[(i + 1) % 3]),
         .b_k         (b_vec[(i + 2) % 3]),
         .scale_value (req_if.scale_value),
         .prod        (lane_prod[i]),
         .result      (lane_res[i])
      );
   end

   vau_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
      .clock          (clock),
      .advance        (advance),
      .kind           (req_if.kind),
      .scale_value    (req_if.scale_value),
      .prod_x         (lane_prod[0]),
      .prod_y         (lane_prod[1]),
      .prod_z         (lane_prod[2]),
      .result         (merge_res),
      .divide_by_zero (merge_dz)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= {valid_ff[DEPTH-2:0], req_if.valid};
         rsp_valid_ff <= valid_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_x_ff      <= lane_res[0].val;
         out_y_ff      <= lane_res[1].val;
         out_z_ff      <= lane_res[2].val;
         out_scalar_ff <= merge_res.val;
         overflow_ff   <= lane_res[0].ovf | lane_res[1].ovf | lane_res[2].ovf |
                          merge_res.ovf;
         dz_ff         <= merge_dz;
      end
   end

   assign req_if.ready          = advance;
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.out_x          = out_x_ff;
   assign rsp_if.out_y          = out_y_ff;
   assign rsp_if.out_z          = out_z_ff;
   assign rsp_if.out_scalar     = out_scalar_ff;
   assign rsp_if.overflow       = overflow_ff;
   assign rsp_if.divide_by_zero = dz_ff;

`ifndef SYNTHESIS
   // A zero divisor saturates without counting as overflow.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.divide_by_zero |-> !rsp_if.overflow)
      else $error("overflow raised together with divide by zero");

   // Scalar results come only from dot and magnitude, which leave the vector at zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.out_scalar != 32'sd0 |->
         rsp_if.out_x == 32'sd0 && rsp_if.out_y == 32'sd0 && rsp_if.out_z == 32'sd0)
      else $error("scalar and vector results both nonzero");

   // No result may appear in the cycle after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_if.valid)
      else $error("result valid right after reset");
`endif

endmodule

### verif/testbench.sv
// Self-checking testbench for the three-component vector arithmetic unit.
module testbench;

   localparam int FRAC = vau_pkg::FRAC_BITS_DEF;
   localparam int LATENCY = FRAC + 35;
   localparam longint CYCLE_LIMIT = 400000;
   localparam longint MAX64 = 64'sh0000_0000_7FFF_FFFF;
   localparam longint MIN64 = -64'sh0000_0000_8000_0000;

   typedef struct {
      vau_pkg::kind_type kind;
      logic signed [31:0] a [3];
      logic signed [31:0] b [3];
      logic signed [31:0] s;
   } vec_op_type;

   typedef struct {
      logic signed [31:0] v [3];
      logic signed [31:0] sc;
      logic ovf;
      logic dz;
   } vec_res_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   vau_req_if req_if ();
   vau_rsp_if rsp_if ();

   vector3_arithmetic_unit #(.FRAC_BITS(FRAC)) i_dut (
      .clock(clock), .reset(reset), .req_if(req_if.sink), .rsp_if(rsp_if.source)
   );

   always #10 clock = ~clock;

   vec_op_type  pending_ops [$];
   vec_res_type expected_results [$];
   int error_count = 0;
   longint cycle_count = 0;
   bit stim_done = 1'b0;
   bit quiet = 1'b0;
   int send_gap = 0;
   int recv_gap = 0;

   function automatic longint clamp(input longint v, inout logic ovf);
      if (v > MAX64) begin
         ovf = 1'b1;
         return MAX64;
      end
      if (v < MIN64) begin
         ovf = 1'b1;
         return MIN64;
      end
      return v;
   endfunction

   // Products are summed exactly in 66 bits, then rounded half up.
   function automatic longint round_products(input logic signed [65:0] sum, inout logic ovf);
      logic signed [65:0] t;
      t = (sum + (66'sd1 <<< (FRAC - 1))) >>> FRAC;
      if (t > 66'(MAX64)) begin
         ovf = 1'b1;
         return MAX64;
      end
      if (t < 66'(MIN64)) begin
         ovf = 1'b1;
         return MIN64;
      end
      return longint'(t);
   endfunction

   function automatic logic [63:0] root_floor(input logic [65:0] n);
      logic [65:0] lo, hi, mid;
      lo = '0;
      hi = 66'h1_0000_0000;
      while (lo < hi) begin
         mid = (lo + hi + 66'd1) >> 1;
         if (mid * mid <= n) lo = mid;
         else hi = mid - 66'd1;
      end
      return lo[63:0];
   endfunction

   function automatic vec_res_type compute_vector_op(input vec_op_type op);
      vec_res_type r;
      logic ovf;
      longint av, bv, q;
      logic signed [65:0] acc;
      logic [65:0] sq;
      logic [63:0] m;
      int j, k;
      ovf = 1'b0;
      r.sc = '0;
      r.dz = 1'b0;
      for (int i = 0; i < 3; i++) r.v[i] = '0;
      case (op.kind)
         vau_pkg::KIND_ADD, vau_pkg::KIND_SUB, vau_pkg::KIND_NEGATE, vau_pkg::KIND_PASS,
         vau_pkg::KIND_SCALE, vau_pkg::KIND_DIVIDE: begin
            for (int i = 0; i < 3; i++) begin
               av = op.a[i];
               bv = op.b[i];
               case (op.kind)
                  vau_pkg::KIND_ADD: r.v[i] = 32'(clamp(av + bv, ovf));
                  vau_pkg::KIND_SUB: r.v[i] = 32'(clamp(av - bv, ovf));
                  vau_pkg::KIND_NEGATE: r.v[i] = 32'(clamp(-av, ovf));
                  vau_pkg::KIND_PASS: r.v[i] = op.a[i];
                  vau_pkg::KIND_SCALE: begin
                     acc = 66'(av) * 66'(longint'(op.s));
                     r.v[i] = 32'(round_products(acc, ovf));
                  end
                  default: begin
                     if (op.s == 0) begin
                        r.v[i] = 32'(av > 0 ? MAX64 : (av < 0 ? MIN64 : 64'sd0));
                     end else begin
                        q = (av * (64'sd1 <<< FRAC)) / longint'(op.s);
                        r.v[i] = 32'(clamp(q, ovf));
                     end
                  end
               endcase
            end
            r.dz = (op.kind == vau_pkg::KIND_DIVIDE) && (op.s == 0);
         end
         vau_pkg::KIND_DOT: begin
            acc = '0;
            for (int i = 0; i < 3; i++) acc += 66'(op.a[i]) * 66'(op.b[i]);
            r.sc = 32'(round_products(acc, ovf));
         end
         vau_pkg::KIND_CROSS: begin
            for (int i = 0; i < 3; i++) begin
               j = (i + 1) % 3;
               k = (i + 2) % 3;
               acc = 66'(op.a[j]) * 66'(op.b[k]) - 66'(op.a[k]) * 66'(op.b[j]);
               r.v[i] = 32'(round_products(acc, ovf));
            end
         end
         vau_pkg::KIND_MAG: begin
            sq = '0;
            for (int i = 0; i < 3; i++) sq += 66'(op.a[i]) * 66'(op.a[i]);
            m = root_floor(sq);
            if (m > 64'h7FFF_FFFF) begin
               ovf = 1'b1;
               m = 64'h7FFF_FFFF;
            end
            r.sc = m[31:0];
         end
         default: ;
      endcase
      r.ovf = ovf;
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, field, got, want);
      error_count++;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return '0;
         3: return 32'(int'($urandom_range(0, 8)) - 4) <<< FRAC;
         4, 5: return 32'(int'($urandom_range(0, 2000000)) - 1000000);
         default: return $urandom;
      endcase
   endfunction

   task automatic add_op(input vau_pkg::kind_type kind, input logic [31:0] av,
                         input logic [31:0] bv, input logic [31:0] s);
      vec_op_type op;
      op.kind = kind;
      for (int i = 0; i < 3; i++) begin
         op.a[i] = av;
         op.b[i] = bv;
      end
      op.s = s;
      pending_ops.push_back(op);
   endtask

   initial begin
      vec_op_type op;
      for (int k = 0; k <= 15; k++) add_op(vau_pkg::kind_type'(k), 32'h0003_8000,
                                           32'hFFFE_4000, 32'h0002_0000);
      add_op(vau_pkg::KIND_NEGATE, 32'h8000_0000, '0, '0);
      add_op(vau_pkg::KIND_DIVIDE, 32'h0001_0000, '0, '0);
      add_op(vau_pkg::KIND_DIVIDE, 32'h8000_0000, '0, '0);
      add_op(vau_pkg::KIND_DIVIDE, '0, '0, '0);
      add_op(vau_pkg::KIND_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0);
      add_op(vau_pkg::KIND_SUB, 32'h8000_0000, 32'h7FFF_FFFF, '0);
      add_op(vau_pkg::KIND_MAG, 32'h8000_0000, 32'h8000_0000, '0);
      add_op(vau_pkg::KIND_DOT, 32'h8000_0000, 32'h8000_0000, '0);
      add_op(vau_pkg::KIND_SCALE, 32'h0000_8000, 32'h0, 32'h0000_0001);
      for (int n = 0; n < 1550; n++) begin
         op.kind = ($urandom_range(0, 19) == 0)
                   ? vau_pkg::kind_type'($urandom_range(9, 15))
                   : vau_pkg::kind_type'($urandom_range(0, 8));
         for (int i = 0; i < 3; i++) begin
            op.a[i] = pick_value();
            op.b[i] = pick_value();
         end
         op.s = pick_value();
         pending_ops.push_back(op);
      end
   end

   // Driver: no gaps are inserted among the last 199 items.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid) expected_results.push_back(compute_vector_op(pending_ops.pop_front()));
         quiet = pending_ops.size() < 200;
         if (send_gap > 0) begin
            send_gap--;
            req_if.valid <= 1'b0;
         end else if (pending_ops.size() == 0) begin
            req_if.valid <= 1'b0;
            stim_done <= 1'b1;
         end else begin
            if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 9);
            req_if.valid <= 1'b1;
            req_if.kind <= pending_ops[0].kind;
            req_if.ax <= pending_ops[0].a[0];
            req_if.ay <= pending_ops[0].a[1];
            req_if.az <= pending_ops[0].a[2];
            req_if.bx <= pending_ops[0].b[0];
            req_if.by <= pending_ops[0].b[1];
            req_if.bz <= pending_ops[0].b[2];
            req_if.scale_value <= pending_ops[0].s;
         end
      end
   end

   // Monitor: compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      vec_res_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            $display("unexpected result at cycle %0d", cycle_count);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_if.out_x !== want.v[0]) report_mismatch("out_x", rsp_if.out_x, want.v[0]);
            if (rsp_if.out_y !== want.v[1]) report_mismatch("out_y", rsp_if.out_y, want.v[1]);
            if (rsp_if.out_z !== want.v[2]) report_mismatch("out_z", rsp_if.out_z, want.v[2]);
            if (rsp_if.out_scalar !== want.sc)
               report_mismatch("out_scalar", rsp_if.out_scalar, want.sc);
            if (rsp_if.overflow !== want.ovf)
               report_mismatch("overflow", 32'(rsp_if.overflow), 32'(want.ovf));
            if (rsp_if.divide_by_zero !== want.dz)
               report_mismatch("divide_by_zero", 32'(rsp_if.divide_by_zero), 32'(want.dz));
         end
      end
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_if.ready <= 1'b0;
      end else begin
         if (!quiet && $urandom_range(0, 7) == 0) recv_gap = $urandom_range(1, 9);
         rsp_if.ready <= 1'b1;
      end
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.kind = vau_pkg::KIND_ADD;
      req_if.ax = '0;
      req_if.ay = '0;
      req_if.az = '0;
      req_if.bx = '0;
      req_if.by = '0;
      req_if.bz = '0;
      req_if.scale_value = '0;
      rsp_if.ready = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (!(stim_done && expected_results.size() == 0) && cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout at cycle %0d", cycle_count);
         $display("TEST FAILED");
      end else if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### sim.f
sv/vau_pkg.sv
sv/vau_req_if.sv
sv/vau_rsp_if.sv
sv/vau_div.sv
sv/vau_sqrt.sv
sv/vau_lane.sv
sv/vau_merge.sv
sv/vector3_arithmetic_unit.sv
verif/testbench.sv
